// ===== rtl/core/hrpl_pkg.sv =====
// Shared types, constants and a helper function for the hex range prefix length block.
`default_nettype none
package hrpl_pkg;

    localparam int unsigned MAX_DIGITS = 32;
    localparam int unsigned CNT_W      = $clog2(MAX_DIGITS + 1);

    localparam logic [7:0] CH_NUL  = 8'h00;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_A    = 8'h61;
    localparam logic [7:0] CH_F    = 8'h66;

    typedef enum logic [3:0] {
        PH_MATCH = 4'b0001,
        PH_TAIL  = 4'b0010,
        PH_VALID = 4'b0100,
        PH_BAD   = 4'b1000
    } t_phase;

    typedef struct packed {
        logic [7:0] a_char;
        logic [7:0] b_char;
        logic       last_pos;
    } t_item;

    typedef struct packed {
        logic [7:0] prefix_bits;
        logic       valid_res;
    } t_result;

    typedef struct packed {
        logic       bad;
        logic [3:0] value;
    } t_hex;

    function automatic t_hex hex_decode(input logic [7:0] c);
        t_hex h;
        h.bad   = 1'b0;
        h.value = 4'h0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            h.value = 4'(c - CH_ZERO);
        end else if (c >= CH_A && c <= CH_F) begin
            h.value = 4'(c - CH_A + 8'd10);
        end else begin
            h.bad = 1'b1;
        end
        return h;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/hrpl_step.sv =====
// Per-position phase, bit count and digit count update for one address pair.
`default_nettype none
module hrpl_step
    import hrpl_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_en,
    input  wire t_item   i_item,
    output logic         o_emit,
    output t_result      o_res
);

    t_phase           r_phase,     n_phase;
    logic [7:0]       r_bit_total, n_bit_total;
    logic [CNT_W-1:0] r_digit_cnt, n_digit_cnt;

    t_hex       w_ha, w_hb;
    logic [3:0] w_x;
    logic [3:0] w_low;
    logic [1:0] w_k;

    always_comb begin
        w_ha = hex_decode(i_item.a_char);
        w_hb = hex_decode(i_item.b_char);
        w_x  = w_ha.value ^ w_hb.value;
        priority if (w_x[3]) begin
            w_k   = 2'd0;
            w_low = 4'b1111;
        end else if (w_x[2]) begin
            w_k   = 2'd1;
            w_low = 4'b0111;
        end else if (w_x[1]) begin
            w_k   = 2'd2;
            w_low = 4'b0011;
        end else begin
            w_k   = 2'd3;
            w_low = 4'b0001;
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_bit_total = r_bit_total;
        n_digit_cnt = r_digit_cnt;
        o_emit      = 1'b0;
        o_res       = '0;

        if (r_phase == PH_MATCH || r_phase == PH_TAIL) begin
            if (i_item.a_char == CH_NUL) begin
                n_phase = (i_item.b_char == CH_NUL) ? PH_VALID : PH_BAD;
            end else if (r_digit_cnt >= CNT_W'(MAX_DIGITS)) begin
                n_phase = PH_BAD;
            end else begin
                n_digit_cnt = r_digit_cnt + CNT_W'(1);
                if (r_phase == PH_MATCH) begin
                    if (w_ha.bad || w_hb.bad) begin
                        n_phase = PH_BAD;
                    end else if (w_x == 4'h0) begin
                        n_bit_total = r_bit_total + 8'd4;
                    end else if ((w_ha.value & w_low) == 4'h0 &&
                                 (w_hb.value & w_low) == w_low) begin
                        n_bit_total = r_bit_total + 8'(w_k);
                        n_phase     = PH_TAIL;
                    end else begin
                        n_phase = PH_BAD;
                    end
                end else if (i_item.a_char != CH_ZERO || i_item.b_char != CH_F) begin
                    n_phase = PH_BAD;
                end
            end
        end

        if (i_item.last_pos) begin
            o_emit          = 1'b1;
            o_res.valid_res = (n_phase != PH_BAD);
            o_res.prefix_bits = o_res.valid_res ? n_bit_total : 8'd0;
            n_phase     = PH_MATCH;
            n_bit_total = 8'd0;
            n_digit_cnt = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_MATCH;
            r_bit_total <= 8'd0;
            r_digit_cnt <= '0;
        end else if (i_en) begin
            r_phase     <= n_phase;
            r_bit_total <= n_bit_total;
            r_digit_cnt <= n_digit_cnt;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/hrpl_out_reg.sv =====
// Result register on the master side.
`default_nettype none
module hrpl_out_reg
    import hrpl_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_load,
    input  wire t_result i_res,
    input  wire logic    i_m_tready,
    output logic         o_m_tvalid,
    output t_result      o_res
);

    logic    r_valid, n_valid;
    t_result r_res;

    always_comb begin
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_m_tready) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_res      = r_res;

endmodule
`default_nettype wire

// ===== rtl/core/hex_range_prefix_length.sv =====
// Top level of the hex range prefix length block.
//
// Each slave transaction carries one character position of two lower-case hex
// address strings (byte 0 ends a string); tlast marks the final position of a
// pair, and on that transaction one result follows: the prefix length in bits
// and a valid flag (length 0 when invalid). A transaction is taken into an
// input register; the phase/count update and result are formed combinationally
// from there into the output register, so one position per clock is sustained
// when the master side is ready. The output register, which drives the master
// side, takes a result when its last position leaves the input register. A
// stalled result holds the input register and then the slave side.
`default_nettype none
module hex_range_prefix_length
    import hrpl_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [7:0] a_char, [15:8] b_char
    input  wire logic        s_axis_tlast,   // last_pos
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [7:0] prefix_bits
    output logic             m_axis_tuser    // [0] valid_res
);

    logic    r_in_valid, n_in_valid;
    t_item   r_item;
    logic    w_out_free;
    logic    w_step_en;
    logic    w_accept;
    logic    w_emit;
    t_result w_res;
    t_result w_out_res;

    assign w_out_free    = !m_axis_tvalid || m_axis_tready;
    assign w_step_en     = r_in_valid && w_out_free;
    assign s_axis_tready = !r_in_valid || w_out_free;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    always_comb begin
        if (w_accept) begin
            n_in_valid = 1'b1;
        end else if (w_step_en) begin
            n_in_valid = 1'b0;
        end else begin
            n_in_valid = r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item.a_char   <= s_axis_tdata[7:0];
            r_item.b_char   <= s_axis_tdata[15:8];
            r_item.last_pos <= s_axis_tlast;
        end
    end

    hrpl_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_step_en),
        .i_item  (r_item),
        .o_emit  (w_emit),
        .o_res   (w_res)
    );

    hrpl_out_reg u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_step_en && w_emit),
        .i_res      (w_res),
        .i_m_tready (m_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .o_res      (w_out_res)
    );

    assign m_axis_tdata = w_out_res.prefix_bits;
    assign m_axis_tuser = w_out_res.valid_res;

endmodule
`default_nettype wire

// ===== rtl/core/hrpl_checker.sv =====
// Port-level checker for the hex range prefix length block and its bind.
`default_nettype none
module hrpl_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [7:0]  m_axis_tdata,
    input wire logic        m_axis_tuser
);

    a_no_result_after_reset: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !m_axis_tvalid)
        else $error("result transaction right after reset");

    a_invalid_has_zero_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == 8'd0))
        else $error("invalid result with nonzero prefix length");

    a_len_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata <= 8'd128))
        else $error("prefix length above 128");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result transaction changed");

endmodule

bind hex_range_prefix_length hrpl_checker u_hrpl_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire

// ===== bench/hex_range_prefix_length_test.sv =====
// Self-checking stream testbench for the hex range prefix length block.
`default_nettype none
module hex_range_prefix_length_test
    import hrpl_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned ITEM_TARGET  = 900;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned REPORT_LIMIT = 10;

    localparam int END_MARKER  = 0;
    localparam int END_ON_DIGIT = 1;
    localparam int END_AND_JUNK = 2;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;   // [7:0] a_char, [15:8] b_char
    logic        s_axis_tlast = 1'b0; // last_pos
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;        // [7:0] prefix_bits
    logic        m_axis_tuser;        // [0] valid_res

    t_item       pending_positions[$];
    t_result     expected_prefixes[$];
    logic [7:0]  text_a[$];
    logic [7:0]  text_b[$];

    t_phase      scan_phase = PH_MATCH;
    logic [7:0]  scan_bits = '0;
    int unsigned scan_digits = 0;

    int unsigned total_positions = 0;
    int unsigned positions_taken = 0;
    int unsigned src_gap = 0;
    int unsigned snk_wait = 0;
    int unsigned results_seen = 0;
    int unsigned hold_left = 0;
    int unsigned hold_mark = 20;
    int unsigned failures = 0;
    int unsigned cycle_count = 0;

    hex_range_prefix_length i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [4:0] nibble_of(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) begin
            return {1'b0, c[3:0]};
        end
        if (c >= 8'h61 && c <= 8'h66) begin
            return {1'b0, 4'(c[3:0] + 4'd9)};
        end
        return 5'b10000;
    endfunction

    function automatic logic [7:0] hex_char(input int unsigned d);
        return (d < 10) ? 8'(CH_ZERO + d) : 8'(CH_A + d - 10);
    endfunction

    function automatic void track_position(input t_item it);
        logic [4:0] na;
        logic [4:0] nb;
        logic [3:0] diff;
        logic [3:0] low;
        int unsigned k;
        t_result r;
        if (scan_phase == PH_MATCH || scan_phase == PH_TAIL) begin
            if (it.a_char == CH_NUL) begin
                scan_phase = (it.b_char == CH_NUL) ? PH_VALID : PH_BAD;
            end else if (scan_digits >= MAX_DIGITS) begin
                scan_phase = PH_BAD;
            end else begin
                scan_digits++;
                if (scan_phase == PH_MATCH) begin
                    na = nibble_of(it.a_char);
                    nb = nibble_of(it.b_char);
                    if (na[4] || nb[4]) begin
                        scan_phase = PH_BAD;
                    end else if (na == nb) begin
                        scan_bits = scan_bits + 8'd4;
                    end else begin
                        diff = na[3:0] ^ nb[3:0];
                        k = diff[3] ? 0 : diff[2] ? 1 : diff[1] ? 2 : 3;
                        low = 4'((1 << (4 - k)) - 1);
                        if ((na[3:0] & low) == 4'h0 && (nb[3:0] & low) == low) begin
                            scan_bits = scan_bits + 8'(k);
                            scan_phase = PH_TAIL;
                        end else begin
                            scan_phase = PH_BAD;
                        end
                    end
                end else if (it.a_char != CH_ZERO || it.b_char != CH_F) begin
                    scan_phase = PH_BAD;
                end
            end
        end
        if (it.last_pos) begin
            if (scan_phase == PH_MATCH || scan_phase == PH_TAIL) begin
                scan_phase = PH_VALID;
            end
            r.valid_res   = (scan_phase == PH_VALID);
            r.prefix_bits = r.valid_res ? scan_bits : 8'd0;
            expected_prefixes.push_back(r);
            scan_phase  = PH_MATCH;
            scan_bits   = '0;
            scan_digits = 0;
        end
    endfunction

    function automatic void note_failure(input string what);
        if (failures < REPORT_LIMIT) begin
            $display("%0t: %s", $realtime, what);
        end
        failures++;
    endfunction

    task automatic put(input logic [7:0] a, input logic [7:0] b, input logic last);
        t_item it;
        it.a_char   = a;
        it.b_char   = b;
        it.last_pos = last;
        pending_positions.push_back(it);
    endtask

    task automatic load_text(input string a, input string b);
        text_a.delete();
        text_b.delete();
        for (int i = 0; i < a.len(); i++) begin
            text_a.push_back(a[i]);
        end
        for (int i = 0; i < b.len(); i++) begin
            text_b.push_back(b[i]);
        end
    endtask

    task automatic emit_pair(input int ending);
        int n;
        logic [7:0] ca;
        logic [7:0] cb;
        int junk;
        n = (text_a.size() > text_b.size()) ? text_a.size() : text_b.size();
        if (ending == END_ON_DIGIT && n == 0) begin
            ending = END_MARKER;
        end
        for (int i = 0; i < n; i++) begin
            ca = (i < text_a.size()) ? text_a[i] : CH_NUL;
            cb = (i < text_b.size()) ? text_b[i] : CH_NUL;
            put(ca, cb, ending == END_ON_DIGIT && i == n - 1);
        end
        if (ending != END_ON_DIGIT) begin
            put(CH_NUL, CH_NUL, ending == END_MARKER);
        end
        if (ending == END_AND_JUNK) begin
            junk = $urandom_range(1, 3);
            for (int j = 0; j < junk; j++) begin
                put(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), j == junk - 1);
            end
        end
    endtask

    task automatic build_block(input int n);
        int p;
        int unsigned k;
        int unsigned low;
        int unsigned top;
        int unsigned d;
        text_a.delete();
        text_b.delete();
        p = $urandom_range(0, n);
        for (int i = 0; i < p; i++) begin
            d = $urandom_range(0, 15);
            text_a.push_back(hex_char(d));
            text_b.push_back(hex_char(d));
        end
        if (p < n) begin
            k = $urandom_range(0, 3);
            low = (1 << (4 - k)) - 1;
            top = $urandom_range(0, 15);
            text_a.push_back(hex_char(top & ~low & 15));
            text_b.push_back(hex_char(top | low));
            for (int i = p + 1; i < n; i++) begin
                text_a.push_back(CH_ZERO);
                text_b.push_back(CH_F);
            end
        end
    endtask

    task automatic fill_stimulus();
        int kind;
        int n;
        int pos;
        load_text("", "");       emit_pair(END_MARKER);
        load_text("ff", "ff");   emit_pair(END_ON_DIGIT);
        load_text("a0", "af");   emit_pair(END_MARKER);
        load_text("8", "b");     emit_pair(END_ON_DIGIT);
        load_text("C0", "Cf");   emit_pair(END_ON_DIGIT);
        load_text("1g", "1f");   emit_pair(END_ON_DIGIT);
        load_text("12", "1");    emit_pair(END_MARKER);
        load_text("1", "12");    emit_pair(END_MARKER);
        load_text("3", "5");     emit_pair(END_ON_DIGIT);
        load_text("00", "f1");   emit_pair(END_ON_DIGIT);
        load_text("x1", "00");   emit_pair(END_AND_JUNK);
        put(8'hff, 8'h00, 1'b0);
        put(8'h00, 8'hff, 1'b1);
        while (pending_positions.size() < ITEM_TARGET) begin
            kind = $urandom_range(0, 9);
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(24, MAX_DIGITS) : $urandom_range(1, 8);
            if (kind == 8) begin
                n = $urandom_range(MAX_DIGITS + 1, MAX_DIGITS + 3);
            end
            build_block(n);
            if (kind == 6) begin
                pos = $urandom_range(0, n - 1);
                if ($urandom_range(0, 1) != 0) begin
                    text_a[pos] = 8'($urandom_range(0, 255));
                end else begin
                    text_b[pos] = 8'($urandom_range(0, 255));
                end
            end else if (kind == 7) begin
                if ($urandom_range(0, 1) != 0) begin
                    text_a.delete(text_a.size() - 1);
                end else begin
                    text_b.delete(text_b.size() - 1);
                end
            end else if (kind == 9) begin
                text_a.delete();
                text_b.delete();
                repeat ($urandom_range(1, 6)) begin
                    text_a.push_back(8'($urandom_range(1, 255)));
                    text_b.push_back(8'($urandom_range(0, 255)));
                end
            end
            emit_pair($urandom_range(END_MARKER, END_AND_JUNK));
        end
        total_positions = pending_positions.size();
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            src_gap = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                track_position(t_item'{s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tlast});
                positions_taken++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (src_gap != 0) begin
                    src_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_positions.size() != 0) begin
                    s_axis_tdata  <= {pending_positions[0].b_char, pending_positions[0].a_char};
                    s_axis_tlast  <= pending_positions[0].last_pos;
                    s_axis_tvalid <= 1'b1;
                    void'(pending_positions.pop_front());
                    src_gap = (((positions_taken / 128) % 3) == 2) ? 0 : $urandom_range(0, 4);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (results_seen >= hold_mark) begin
            hold_left <= HOLD_CYCLES;
            hold_mark <= hold_mark + 50;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            snk_wait = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_prefixes.size() == 0) begin
                    note_failure($sformatf("unexpected result bits=%0d valid=%0b",
                                           m_axis_tdata, m_axis_tuser));
                end else begin
                    if (m_axis_tdata !== expected_prefixes[0].prefix_bits) begin
                        note_failure($sformatf("prefix_bits expected %0d actual %0d",
                                               expected_prefixes[0].prefix_bits, m_axis_tdata));
                    end
                    if (m_axis_tuser !== expected_prefixes[0].valid_res) begin
                        note_failure($sformatf("valid_res expected %0b actual %0b",
                                               expected_prefixes[0].valid_res, m_axis_tuser));
                    end
                    void'(expected_prefixes.pop_front());
                end
                results_seen <= results_seen + 1;
                snk_wait = (((results_seen / 16) % 3) == 1) ? 0 : $urandom_range(0, 4);
            end else if (snk_wait != 0) begin
                snk_wait--;
            end
            m_axis_tready <= (snk_wait == 0) && (hold_left == 0);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        fill_stimulus();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (positions_taken < total_positions) @(posedge i_clk);
        while (expected_prefixes.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (failures == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ===== files.f =====
rtl/core/hrpl_pkg.sv
rtl/core/hrpl_step.sv
rtl/core/hrpl_out_reg.sv
rtl/core/hex_range_prefix_length.sv
rtl/core/hrpl_checker.sv
bench/hex_range_prefix_length_test.sv
